@@ rtl/longest_increasing_subsequence_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the longest increasing subsequence block
// Immediate-consequence and next-cycle checks, compiled out in synthesis.
// ---------------------------------------------------------------------------
`ifndef LONGEST_INCREASING_SUBSEQUENCE_DEFINES_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_DEFINES_SVH

`ifndef SYNTHESIS

`define LIS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lis: check failed");

`define LIS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lis: check failed");

`else

`define LIS_ASSERT_NOW(label, clk, rst, ante, cons)

`define LIS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/lis_pkg.sv @@
// ---------------------------------------------------------------------------
// lis_pkg
// Shared types, widths and helpers for the longest increasing subsequence
// block.
// ---------------------------------------------------------------------------
package lis_pkg;

  // Number of distinct values; must be a power of two.
  localparam int VALUE_RANGE = 1024;

  localparam int VALUE_W    = 10;
  localparam int LEN_W      = 11;
  localparam int IDX_W      = $clog2(VALUE_RANGE);
  localparam int ADDR_W     = IDX_W + 1;
  localparam int TREE_DEPTH = 2 * VALUE_RANGE;
  localparam int EPOCH_W    = 4;
  localparam int WORD_W     = EPOCH_W + LEN_W;
  localparam int LVL_W      = $clog2(IDX_W + 1);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               new_sequence;
  } item_t;

  typedef struct packed {
    logic [LEN_W-1:0] length_here;
    logic [LEN_W-1:0] best_so_far;
  } result_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic query;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic q_last;
    logic u_last;
    logic seq_wrap;
    logic out_free;
  } status_t;

  // Values beyond the range saturate to the top leaf.
  function automatic logic [IDX_W-1:0] clip_pos(input logic [VALUE_W-1:0] v);
    logic [IDX_W-1:0] pos;
    if (int'(v) >= VALUE_RANGE) begin
      pos = IDX_W'(VALUE_RANGE - 1);
    end else begin
      pos = IDX_W'(v);
    end
    return pos;
  endfunction

  function automatic logic [LEN_W-1:0] max_len(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

@@ rtl/longest_increasing_subsequence.sv @@
// ---------------------------------------------------------------------------
// longest_increasing_subsequence: streaming LIS lengths over a max tree
// Accepts one item at a time: a new item is taken only after the previous result
// is handed off, as each item takes one tree-memory read per level in a prefix walk
// and an update walk. Reset and every 16th new_sequence sweep the 2048-entry tree.
// ---------------------------------------------------------------------------
module longest_increasing_subsequence (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  lis_pkg::item_t   item,
  output logic             res_valid,
  input  logic             res_ready,
  output lis_pkg::result_t res
);

  lis_pkg::cmd_t    cmd;
  lis_pkg::status_t st;

  lis_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .st         (st),
    .cmd        (cmd)
  );

  lis_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

@@ rtl/lis_ram.sv @@
// ---------------------------------------------------------------------------
// lis_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module lis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lis_ctrl.sv @@
// ---------------------------------------------------------------------------
// lis_ctrl
// Sequencer: clearing pass, prefix-max walk, update walk and result hand-off.
// ---------------------------------------------------------------------------
`include "longest_increasing_subsequence_defines.svh"

module lis_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  lis_pkg::status_t st,
  output lis_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_CLR_INIT = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_CLR_SEQ  = 3'd2;
  localparam logic [2:0] S_QUERY    = 3'd3;
  localparam logic [2:0] S_QWAIT    = 3'd4;
  localparam logic [2:0] S_UPDATE   = 3'd5;
  localparam logic [2:0] S_RESULT   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.load   = accept;
    unique case (state)
      S_CLR_INIT: begin
        cmd.clear = 1'b1;
        if (st.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          // When the epoch tag runs out the whole tree is swept first.
          state_next = st.seq_wrap ? S_CLR_SEQ : S_QUERY;
        end
      end
      S_CLR_SEQ: begin
        cmd.clear = 1'b1;
        if (st.clr_done) begin
          state_next = S_QUERY;
        end
      end
      S_QUERY: begin
        cmd.query = 1'b1;
        if (st.q_last) begin
          state_next = S_QWAIT;
        end
      end
      S_QWAIT: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        if (st.u_last) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLR_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR_INIT;
    end else begin
      state <= state_next;
    end
  end

  `LIS_ASSERT_NOW(a_one_cmd, clk, rst, 1'b1,
    $onehot0({cmd.clear, cmd.load, cmd.query, cmd.update, cmd.emit}))
  `LIS_ASSERT_NEXT(a_accept_starts, clk, rst, accept,
    (state == S_QUERY) || (state == S_CLR_SEQ))
  `LIS_ASSERT_NEXT(a_emit_idles, clk, rst, cmd.emit, item_ready)

endmodule

@@ rtl/lis_datapath.sv @@
// ---------------------------------------------------------------------------
// lis_datapath
// Tree memory with epoch tags, walk counters, accumulator, best length and
// the output register.
// ---------------------------------------------------------------------------
`include "longest_increasing_subsequence_defines.svh"

module lis_datapath (
  input  logic             clk,
  input  logic             rst,
  input  lis_pkg::cmd_t    cmd,
  output lis_pkg::status_t st,
  input  lis_pkg::item_t   item,
  output logic             res_valid,
  input  logic             res_ready,
  output lis_pkg::result_t res
);

  logic [lis_pkg::IDX_W-1:0]   pos;
  logic [lis_pkg::LVL_W-1:0]   level;
  logic [lis_pkg::LEN_W-1:0]   acc;
  logic [lis_pkg::LEN_W-1:0]   best;
  logic [lis_pkg::EPOCH_W-1:0] epoch;
  logic [lis_pkg::ADDR_W-1:0]  clr_addr;
  logic                        rq_inc;
  logic                        ru;
  logic [lis_pkg::ADDR_W-1:0]  ru_addr;

  logic [lis_pkg::ADDR_W-1:0]  leaf;
  logic [lis_pkg::ADDR_W-1:0]  node;
  logic [lis_pkg::ADDR_W-1:0]  raddr;
  logic [lis_pkg::WORD_W-1:0]  rdata;
  logic [lis_pkg::EPOCH_W-1:0] rd_tag;
  logic [lis_pkg::LEN_W-1:0]   live;
  logic [lis_pkg::LEN_W-1:0]   len_here;
  logic [lis_pkg::LEN_W-1:0]   best_next;
  logic                        we;
  logic [lis_pkg::ADDR_W-1:0]  waddr;
  logic [lis_pkg::WORD_W-1:0]  wdata;
  logic                        q_last;
  logic                        u_last;

  // Leaves sit at VALUE_RANGE + pos; node is the path entry at this level.
  assign leaf = {1'b1, pos};
  assign node = leaf >> level;

  // A right child's left sibling covers only smaller values.
  assign raddr = cmd.query ? (node ^ lis_pkg::ADDR_W'(1)) : node;

  assign rd_tag   = rdata[lis_pkg::WORD_W-1 -: lis_pkg::EPOCH_W];
  assign live     = (rd_tag == epoch) ? rdata[lis_pkg::LEN_W-1:0] : '0;
  assign len_here = acc + lis_pkg::LEN_W'(1);
  assign best_next = lis_pkg::max_len(best, len_here);

  assign we    = cmd.clear || ru;
  assign waddr = cmd.clear ? clr_addr : ru_addr;
  assign wdata = cmd.clear ? '0 : {epoch, lis_pkg::max_len(live, len_here)};

  assign q_last = (level == lis_pkg::LVL_W'(lis_pkg::IDX_W - 1));
  assign u_last = (level == lis_pkg::LVL_W'(lis_pkg::IDX_W));

  always_comb begin
    st.clr_done = (clr_addr == lis_pkg::ADDR_W'(lis_pkg::TREE_DEPTH - 1));
    st.q_last   = q_last;
    st.u_last   = u_last;
    st.seq_wrap = item.new_sequence && (epoch == '1);
    st.out_free = !res_valid || res_ready;
  end

  lis_ram #(
    .WIDTH (lis_pkg::WORD_W),
    .DEPTH (lis_pkg::TREE_DEPTH)
  ) u_tree (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      level    <= '0;
      best     <= '0;
      epoch    <= '0;
      clr_addr <= '0;
      rq_inc   <= 1'b0;
      ru       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      rq_inc <= cmd.query && node[0];
      ru     <= cmd.update;

      if ((cmd.query && q_last) || (cmd.update && u_last) || cmd.load) begin
        level <= '0;
      end else if (cmd.query || cmd.update) begin
        level <= level + lis_pkg::LVL_W'(1);
      end

      if (cmd.clear) begin
        clr_addr <= clr_addr + lis_pkg::ADDR_W'(1);
      end

      if (cmd.load && item.new_sequence) begin
        epoch <= epoch + lis_pkg::EPOCH_W'(1);
        best  <= '0;
      end else if (cmd.emit) begin
        best <= best_next;
      end

      if (cmd.emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ru_addr <= node;
    if (cmd.load) begin
      pos <= lis_pkg::clip_pos(item.value);
      acc <= '0;
    end else if (rq_inc) begin
      acc <= lis_pkg::max_len(acc, live);
    end
    if (cmd.emit) begin
      res.length_here <= len_here;
      res.best_so_far <= best_next;
    end
  end

  `LIS_ASSERT_NOW(a_no_rw_clash, clk, rst, ru && cmd.update, ru_addr != node)
  `LIS_ASSERT_NEXT(a_wrap_epoch, clk, rst, cmd.clear && st.clr_done, epoch == '0)
  `LIS_ASSERT_NOW(a_len_nonzero, clk, rst, cmd.emit, len_here != '0)

endmodule
